### sv/rsr_pkg.sv
// rsr_pkg: shared constants, arctangent table and types for ray_segment_range.
// Used by every module of the block but rsr_queue.
`timescale 1ns / 1ps
package rsr_pkg;
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int CORDIC_STEPS = 16;
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  typedef enum logic [1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } reg_idx_t;

  function automatic logic [31:0] arc_tab(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage

### sv/rsr_queue.sv
// rsr_queue: small first-word-fall-through queue between front and back parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rsr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic push, pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### sv/rsr_front.sv
// rsr_front: CORDIC pipeline that turns heading and range into a direction
// vector and forms segment offsets. Depends on rsr_pkg.
`timescale 1ns / 1ps
module rsr_front
  import rsr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W,
  parameter int ANGLE_WIDTH = ANGLE_W,
  localparam int CW = COORD_WIDTH,
  localparam int OUT_W = 6*(CW+1) + CW - 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [CW-1:0]  ox,
  input  logic signed [CW-1:0]  oy,
  input  logic [ANGLE_WIDTH-1:0] hd,
  input  logic [CW-2:0]         mr,
  input  logic signed [CW-1:0]  sx,
  input  logic signed [CW-1:0]  sy,
  input  logic signed [CW-1:0]  ex,
  input  logic signed [CW-1:0]  ey,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data
);
  // stages: 0 = setup, 1..16 = rotations, 17 = clamp, 18 = scale
  localparam int NS = CORDIC_STEPS + 3;
  localparam int PW = CW + 1;

  logic adv;
  logic [NS-1:0] vld;
  logic signed [35:0] x [NS-1];
  logic signed [35:0] y [NS-1];
  logic signed [35:0] z [CORDIC_STEPS+1];
  logic flip [NS];
  logic [CW-2:0] mrs [NS];
  logic signed [CW:0] dxs [NS];
  logic signed [CW:0] dys [NS];
  logic signed [CW:0] vxs [NS];
  logic signed [CW:0] vys [NS];
  logic signed [PW-1:0] px, py;

  // truncate toward zero: scale magnitude, then restore sign
  function automatic logic signed [PW-1:0] scale(input logic [CW-2:0] m,
                                                 input logic signed [35:0] c);
    logic [30:0] cm;
    logic [CW+29:0] p;
    logic [PW-1:0] q;
    cm = c[35] ? 31'(-c) : 31'(c);
    p = (CW+30)'(m) * (CW+30)'(cm);
    q = PW'(p >> 30);
    return c[35] ? -signed'(q) : signed'(q);
  endfunction

  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  logic signed [35:0] z0;
  always_comb begin
    z0 = 36'(signed'({hd, {(32-ANGLE_WIDTH){1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0] <= 36'(CORDIC_X0);
      y[0] <= '0;
      if (z0 > 36'sd1073741824) begin
        z[0] <= z0 - 36'sd2147483648; flip[0] <= 1'b1;
      end else if (z0 < -36'sd1073741824) begin
        z[0] <= z0 + 36'sd2147483648; flip[0] <= 1'b1;
      end else begin
        z[0] <= z0; flip[0] <= 1'b0;
      end
      mrs[0] <= mr;
      dxs[0] <= (CW+1)'(sx) - (CW+1)'(ox);
      dys[0] <= (CW+1)'(sy) - (CW+1)'(oy);
      vxs[0] <= (CW+1)'(ex) - (CW+1)'(sx);
      vys[0] <= (CW+1)'(ey) - (CW+1)'(sy);
      for (int s = 1; s < NS; s++) begin
        mrs[s] <= mrs[s-1]; flip[s] <= flip[s-1];
        dxs[s] <= dxs[s-1]; dys[s] <= dys[s-1];
        vxs[s] <= vxs[s-1]; vys[s] <= vys[s-1];
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - 36'(arc_tab(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + 36'(arc_tab(i));
        end
      end
      // flip and clamp to unit
      begin
        logic signed [35:0] fx, fy;
        fx = flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
        fy = flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
        x[NS-2] <= (fx > 36'sd1073741824) ? 36'sd1073741824 :
                   (fx < -36'sd1073741824) ? -36'sd1073741824 : fx;
        y[NS-2] <= (fy > 36'sd1073741824) ? 36'sd1073741824 :
                   (fy < -36'sd1073741824) ? -36'sd1073741824 : fy;
      end
      px <= scale(mrs[NS-2], x[NS-2]);
      py <= scale(mrs[NS-2], y[NS-2]);
    end
  end

  assign out_data = {mrs[NS-1], vys[NS-1], vxs[NS-1], dys[NS-1], dxs[NS-1],
                     py, px};
endmodule

### sv/rsr_back.sv
// rsr_back: determinant, hit test and pipelined restoring divide for the
// hit distance. Depends on rsr_pkg.
`timescale 1ns / 1ps
module rsr_back
  import rsr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W,
  localparam int CW = COORD_WIDTH,
  localparam int IN_W = 6*(CW+1) + CW - 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CW-2:0]   distance,
  output logic            hit
);
  localparam int VW = CW + 1;
  localparam int WW = 2*VW + 2;
  localparam int QB = CW - 1;
  localparam int NS = 3 + QB;

  logic signed [VW-1:0] px, py, dx, dy, vx, vy;
  logic [CW-2:0] mr;
  assign {mr, vy, vx, dy, dx, py, px} = in_data;

  logic adv;
  logic [NS-1:0] vld;
  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  // stage 0: six products
  logic signed [2*VW-1:0] m_pv, m_pu, m_vd, m_ud, m_pd, m_qd;
  logic [CW-2:0] mr0;
  // stage 1: sums, sign fold
  logic signed [WW-1:0] det1, n11, n21;
  logic [CW-2:0] mr1;
  // stage 2: hit, stages 3 and up: divide
  logic [WW-1:0] det [2:NS-1];
  logic [WW-1:0] n1 [2:NS-1];
  logic [WW-1:0] rem [2:NS-1];
  logic [CW-2:0] mrq [2:NS-1];
  logic [CW-2:0] q [2:NS-1];
  logic hitq [2:NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_pv <= py * vx; m_pu <= px * vy;
      m_vd <= vx * dy; m_ud <= vy * dx;
      m_pd <= px * dy; m_qd <= py * dx;
      mr0 <= mr;
      begin
        logic signed [WW-1:0] d, a, b;
        d = WW'(m_pv) - WW'(m_pu);
        a = WW'(m_vd) - WW'(m_ud);
        b = WW'(m_pd) - WW'(m_qd);
        det1 <= d[WW-1] ? -d : d;
        n11  <= d[WW-1] ? -a : a;
        n21  <= d[WW-1] ? -b : b;
      end
      mr1 <= mr0;
      hitq[2] <= (det1 != 0) && !n11[WW-1] && (n11 <= det1) &&
                 !n21[WW-1] && (n21 != 0) && (n21 <= det1);
      det[2] <= det1; n1[2] <= n11; rem[2] <= '0; q[2] <= '0; mrq[2] <= mr1;
      // one quotient digit a stage, MSB of max_range first; the partial
      // dividend can reach three times det, so a digit may be two
      for (int s = 3; s < NS; s++) begin
        logic [WW-1:0] r;
        logic [1:0] dg;
        r = (rem[s-1] << 1) + (mrq[s-1][QB-1-(s-3)] ? n1[s-1] : '0);
        if (r >= (det[s-1] << 1)) begin
          rem[s] <= r - (det[s-1] << 1);
          dg = 2'd2;
        end else if (r >= det[s-1]) begin
          rem[s] <= r - det[s-1];
          dg = 2'd1;
        end else begin
          rem[s] <= r;
          dg = 2'd0;
        end
        q[s] <= (q[s-1] << 1) + (CW-1)'(dg);
        det[s] <= det[s-1]; n1[s] <= n1[s-1];
        mrq[s] <= mrq[s-1]; hitq[s] <= hitq[s-1];
      end
    end
  end

  assign hit = hitq[NS-1];
  assign distance = hitq[NS-1] ? q[NS-1] : mrq[NS-1];
endmodule

### sv/ray_segment_range.sv
// ray_segment_range: top level, configuration registers, front CORDIC,
// queue and back intersection unit. Depends on rsr_pkg and all rsr_ modules.
`timescale 1ns / 1ps
// Casts one 2D ray per beat against a segment held in registers 0..3
// (start_x, start_y, end_x, end_y). One ray is accepted every cycle
// unless an output stall holds the pipeline; each result passes the 19
// front stages around the 16 CORDIC rotations, the queue and the
// one-bit-a-stage distance divider. A queue between the two halves
// absorbs output stalls. distance is max_range on a miss or parallel
// ray, else t1 * max_range rounded down.
module ray_segment_range
  import rsr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W,
  parameter int ANGLE_WIDTH = ANGLE_W,
  localparam int CW = COORD_WIDTH,
  localparam int IN_BITS = 3*CW - 1 + ANGLE_WIDTH,
  localparam int IN_BYTES = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CW-1:0]       cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  // origin_x, origin_y, heading, max_range
  input  logic [IN_BYTES-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // distance, hit
  output logic [((CW+7)/8)*8-1:0] m_tdata
);
  localparam int QW = 6*(CW+1) + CW - 1;
  logic signed [CW-1:0] sx, sy, ex, ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; ex <= '0; ey <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START_X: sx <= cfg_data;
        REG_START_Y: sy <= cfg_data;
        REG_END_X:   ex <= cfg_data;
        REG_END_Y:   ey <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fv, fr, qv, qr;
  logic [QW-1:0] fd, qd;
  logic [CW-2:0] range_out;
  logic hit;

  rsr_front #(.COORD_WIDTH(CW), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .ox(s_tdata[CW-1:0]), .oy(s_tdata[2*CW-1:CW]),
    .hd(s_tdata[2*CW+ANGLE_WIDTH-1:2*CW]),
    .mr(s_tdata[3*CW+ANGLE_WIDTH-2:2*CW+ANGLE_WIDTH]),
    .sx, .sy, .ex, .ey,
    .out_valid(fv), .out_ready(fr), .out_data(fd)
  );

  rsr_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk, .rst, .in_valid(fv), .in_ready(fr), .in_data(fd),
    .out_valid(qv), .out_ready(qr), .out_data(qd)
  );

  rsr_back #(.COORD_WIDTH(CW)) u_back (
    .clk, .rst, .in_valid(qv), .in_ready(qr), .in_data(qd),
    .out_valid(m_tvalid), .out_ready(m_tready), .distance(range_out), .hit
  );

  assign m_tdata = {{(((CW+7)/8)*8-CW){1'b0}}, hit, range_out};
endmodule
